### hw/rtl/qre_pkg.sv
// Shared types, constants and GF(256) helpers for the QR version 1 codeword encoder.
// No dependencies; used by qre_cell, qre_rs_chain and qr_v1_codeword_ecc_encoder.
package qre_pkg;

	localparam int NUM_ECC_MAX = 17;
	localparam int TOTAL_CAP_BITS = 208;
	localparam logic [8:0] GF_POLY = 9'h11D;
	localparam logic [14:0] FORMAT_XOR = 15'h5412;
	localparam logic [7:0] PAD_EVEN = 8'hEC;
	localparam logic [7:0] PAD_ODD = 8'h11;

	// Generator coefficients per level; unused cells get zero.
	localparam logic [7:0] GEN_TABLE [4][NUM_ECC_MAX] = '{
		'{8'hd8, 8'hc2, 8'h9f, 8'h6f, 8'hc7, 8'h5e, 8'h5f, 8'h71, 8'h9d, 8'hc1,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h7f, 8'h7a, 8'h9a, 8'ha4, 8'h0b, 8'h44, 8'h75, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h77, 8'h42, 8'h53, 8'h78, 8'h77, 8'h16, 8'hc5, 8'h53, 8'hf9, 8'h29,
		  8'h8f, 8'h86, 8'h55, 8'h35, 8'h7d, 8'h63, 8'h4f},
		'{8'h89, 8'h49, 8'he3, 8'h11, 8'hb1, 8'h11, 8'h34, 8'h0d, 8'h2e, 8'h2b,
		  8'h53, 8'h84, 8'h78, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	typedef enum logic [2:0] {
		ST_RUN,
		ST_TERM,
		ST_FILL,
		ST_PAD,
		ST_ECC
	} state_t;

	typedef struct packed {
		logic       shift;
		logic       feed;
		logic       clear;
		logic [1:0] lvl;
		logic [7:0] data;
	} rs_ctrl_t;

	function automatic logic [1:0] level_of(input logic [14:0] fmt);
		logic [14:0] x;
		x = fmt ^ FORMAT_XOR;
		return x[14:13];
	endfunction

	function automatic logic [4:0] ecc_count(input logic [1:0] lvl);
		logic [4:0] c;
		case (lvl)
			2'd0: c = 5'd10;
			2'd1: c = 5'd7;
			2'd2: c = 5'd17;
			2'd3: c = 5'd13;
			default: c = 5'd10;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		r = 8'd0;
		for (int k = 7; k >= 0; k--) begin
			r = r[7] ? (8'({r, 1'b0}) ^ GF_POLY[7:0]) : 8'({r, 1'b0});
			if (b[k]) begin
				r = r ^ a;
			end
		end
		return r;
	endfunction

endpackage

### hw/rtl/qre_cell.sv
// One remainder cell of the Reed-Solomon shift register.
// Depends on qre_pkg for rs_ctrl_t and gf_mul.
module qre_cell import qre_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  rs_ctrl_t   ctrl,
	input  logic [7:0] factor,
	input  logic [7:0] coef,
	input  logic [7:0] next_val,
	output logic [7:0] val
);

	logic [7:0] val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= 8'd0;
		end else if (ctrl.clear) begin
			val_q <= 8'd0;
		end else if (ctrl.shift) begin
			// take the neighbor's byte, add this cell's generator term
			val_q <= next_val ^ gf_mul(coef, factor);
		end
	end

	assign val = val_q;

endmodule

### hw/rtl/qre_rs_chain.sv
// Row of remainder cells forming the GF(256) Reed-Solomon division register.
// Depends on qre_pkg and qre_cell.
module qre_rs_chain import qre_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  rs_ctrl_t   ctrl,
	output logic [7:0] head
);

	logic [7:0] r   [NUM_ECC_MAX];
	logic [7:0] nxt [NUM_ECC_MAX];
	logic [7:0] factor;

	// flush shifts with a zero factor
	assign factor = ctrl.feed ? (ctrl.data ^ r[0]) : 8'd0;
	assign head = r[0];

	for (genvar j = 0; j < NUM_ECC_MAX; j++) begin : g_cell
		if (j == NUM_ECC_MAX - 1) begin : g_top
			assign nxt[j] = 8'd0;
		end else begin : g_mid
			assign nxt[j] = r[j + 1];
		end

		qre_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.factor   (factor),
			.coef     (GEN_TABLE[ctrl.lvl][j]),
			.next_val (nxt[j]),
			.val      (r[j])
		);
	end

endmodule

### hw/rtl/qr_v1_codeword_ecc_encoder.sv
// QR version 1 codeword encoder: bit packer, terminator/pad sequencer, RS remainder row.
// Throughput: one input word per cycle in ST_RUN while the output register is free; a
// completed data codeword is in the output register the cycle after its word is accepted.
// After the last word come the terminator, fill and pad codewords as due, then ecc_count
// ECC codewords; no input is taken meanwhile. Reset (arst_n low) clears all state but the
// output data/user/last registers, format_word 0. Depends on qre_pkg and qre_rs_chain.
module qr_v1_codeword_ecc_encoder import qre_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [14:0] cfg_wdata,  // format_word
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [7:0] payload_bits, [11:8] bit_count, rest zero
	input  logic        s_tlast,    // last_item
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [7:0] codeword
	output logic [1:0]  m_tuser,    // [0] is_ecc, [1] status
	output logic        m_tlast     // last_result
);

	state_t state_q, state_d;

	logic [14:0] fmt_q;
	logic [7:0]  acc_q, acc_d;
	logic [2:0]  abits_q, abits_d;
	logic [7:0]  total_q, total_d;
	logic [4:0]  sent_q, sent_d;
	logic        ovf_q, ovf_d;
	logic        pad_q, pad_d;
	logic [4:0]  eidx_q, eidx_d;

	logic        m_valid_q;
	logic [7:0]  m_data_q;
	logic [1:0]  m_user_q;
	logic        m_last_q;

	logic        emit;
	logic [7:0]  e_word;
	logic        e_ecc, e_status, e_last;

	logic [1:0]  lvl;
	logic [4:0]  deg;
	logic [7:0]  cap_bits;
	logic [4:0]  cap_cw;
	logic        slot;
	logic        accept;

	logic [3:0]  n;
	logic [8:0]  sum9;
	logic        over;
	logic [7:0]  mask8;
	logic [15:0] w16;
	logic [3:0]  tot;
	logic        full;
	logic [2:0]  shr;
	logic [7:0]  run_byte;
	logic [7:0]  rem_mask;

	logic [7:0]  room;
	logic [3:0]  term;
	logic [3:0]  zbits;
	logic [7:0]  head;

	rs_ctrl_t    rs_ctrl;

	assign lvl      = level_of(fmt_q);
	assign deg      = ecc_count(lvl);
	assign cap_bits = 8'(TOTAL_CAP_BITS - 8 * int'(deg));
	assign cap_cw   = 5'(TOTAL_CAP_BITS / 8 - int'(deg));
	assign slot     = !m_valid_q || m_tready;
	assign s_tready = (state_q == ST_RUN) && slot;
	assign accept   = s_tvalid && s_tready;

	// pack the incoming bits behind the held ones
	assign n        = s_tdata[11] ? 4'd8 : s_tdata[11:8];
	assign sum9     = {1'b0, total_q} + {5'd0, n};
	assign over     = sum9 > {1'b0, cap_bits};
	assign mask8    = 8'((9'd1 << n) - 9'd1);
	assign w16      = ({8'd0, acc_q} << n) | {8'd0, s_tdata[7:0] & mask8};
	assign tot      = {1'b0, abits_q} + n;
	assign full     = tot[3];
	assign shr      = tot[2:0];
	assign run_byte = 8'(w16 >> shr);
	assign rem_mask = 8'((9'd1 << shr) - 9'd1);

	assign room  = cap_bits - total_q;
	assign term  = (room > 8'd4) ? 4'd4 : room[3:0];
	assign zbits = {1'b0, abits_q} + term;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN: begin
				if (accept && s_tlast && !(ovf_q || over)) begin
					state_d = ST_TERM;
				end
			end
			ST_TERM: begin
				if (slot) begin
					state_d = (zbits > 4'd8) ? ST_FILL : ST_PAD;
				end
			end
			ST_FILL: begin
				if (slot) begin
					state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (sent_q >= cap_cw) begin
					state_d = ST_ECC;
				end
			end
			ST_ECC: begin
				if (slot && (eidx_q + 5'd1 == deg)) begin
					state_d = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_comb begin
		emit     = 1'b0;
		e_word   = 8'd0;
		e_ecc    = 1'b0;
		e_status = 1'b0;
		e_last   = 1'b0;
		rs_ctrl  = '{shift: 1'b0, feed: 1'b0, clear: 1'b0, lvl: lvl, data: 8'd0};
		acc_d    = acc_q;
		abits_d  = abits_q;
		total_d  = total_q;
		sent_d   = sent_q;
		ovf_d    = ovf_q;
		pad_d    = pad_q;
		eidx_d   = eidx_q;

		case (state_q)
			ST_RUN: begin
				if (accept) begin
					if (!ovf_q && !over) begin
						total_d = sum9[7:0];
						if (full) begin
							emit          = 1'b1;
							e_word        = run_byte;
							rs_ctrl.shift = 1'b1;
							rs_ctrl.feed  = 1'b1;
							rs_ctrl.data  = run_byte;
							sent_d        = sent_q + 5'd1;
							acc_d         = w16[7:0] & rem_mask;
							abits_d       = shr;
						end else begin
							acc_d   = w16[7:0];
							abits_d = tot[2:0];
						end
					end else begin
						ovf_d = 1'b1;
						if (s_tlast) begin
							// single status word, then start a fresh symbol
							emit          = 1'b1;
							e_status      = 1'b1;
							e_last        = 1'b1;
							rs_ctrl.clear = 1'b1;
							acc_d         = 8'd0;
							abits_d       = 3'd0;
							total_d       = 8'd0;
							sent_d        = 5'd0;
							ovf_d         = 1'b0;
							pad_d         = 1'b0;
							eidx_d        = 5'd0;
						end
					end
				end
			end
			ST_TERM: begin
				if (slot && zbits != 4'd0) begin
					emit          = 1'b1;
					e_word        = 8'(acc_q << (4'd8 - {1'b0, abits_q}));
					rs_ctrl.shift = 1'b1;
					rs_ctrl.feed  = 1'b1;
					rs_ctrl.data  = e_word;
					sent_d        = sent_q + 5'd1;
					acc_d         = 8'd0;
					abits_d       = 3'd0;
				end
			end
			ST_FILL: begin
				if (slot) begin
					emit          = 1'b1;
					rs_ctrl.shift = 1'b1;
					rs_ctrl.feed  = 1'b1;
					sent_d        = sent_q + 5'd1;
				end
			end
			ST_PAD: begin
				if (sent_q < cap_cw && slot) begin
					emit          = 1'b1;
					e_word        = pad_q ? PAD_ODD : PAD_EVEN;
					rs_ctrl.shift = 1'b1;
					rs_ctrl.feed  = 1'b1;
					rs_ctrl.data  = e_word;
					sent_d        = sent_q + 5'd1;
					pad_d         = !pad_q;
				end
			end
			ST_ECC: begin
				if (slot) begin
					emit          = 1'b1;
					e_word        = head;
					e_ecc         = 1'b1;
					rs_ctrl.shift = 1'b1;
					eidx_d        = eidx_q + 5'd1;
					if (eidx_q + 5'd1 == deg) begin
						e_last        = 1'b1;
						rs_ctrl.clear = 1'b1;
						acc_d         = 8'd0;
						abits_d       = 3'd0;
						total_d       = 8'd0;
						sent_d        = 5'd0;
						ovf_d         = 1'b0;
						pad_d         = 1'b0;
						eidx_d        = 5'd0;
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			fmt_q   <= 15'd0;
			acc_q   <= 8'd0;
			abits_q <= 3'd0;
			total_q <= 8'd0;
			sent_q  <= 5'd0;
			ovf_q   <= 1'b0;
			pad_q   <= 1'b0;
			eidx_q  <= 5'd0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				fmt_q <= cfg_wdata;
			end
			acc_q   <= acc_d;
			abits_q <= abits_d;
			total_q <= total_d;
			sent_q  <= sent_d;
			ovf_q   <= ovf_d;
			pad_q   <= pad_d;
			eidx_q  <= eidx_d;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_data_q <= e_word;
			m_user_q <= {e_status, e_ecc};
			m_last_q <= e_last;
		end
	end

	qre_rs_chain u_rs_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (rs_ctrl),
		.head   (head)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

endmodule

### bench/tb_qr_v1_codeword_ecc_encoder.sv
`timescale 1ns / 100ps
// Testbench for qr_v1_codeword_ecc_encoder: directed and random payload chunks over all
// four ECC levels, checked word by word against a built-in packer / pad / RS predictor.
// Self-contained; needs only the block's RTL.

typedef enum logic [1:0] {
	LVL_M,
	LVL_L,
	LVL_H,
	LVL_Q
} ecc_level_e;

typedef struct packed {
	logic [7:0] codeword;
	logic       is_ecc;
	logic       status;
	logic       last;
} qr_word_t;

class codeword_scoreboard;
	localparam int SYMBOL_BITS = 208;
	localparam logic [14:0] FMT_MASK = 15'h5412;
	localparam logic [7:0] PAD_A = 8'hEC;
	localparam logic [7:0] PAD_B = 8'h11;
	localparam logic [7:0] FIELD_POLY = 8'h1D;
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_TOO_LONG = 1'b1;

	logic [14:0] format_word;
	logic [7:0] bit_buf;
	int unsigned buf_bits;
	int unsigned payload_bits;
	int unsigned data_sent;
	logic [7:0] remainder [17];
	bit too_long;
	qr_word_t codewords_due [$];
	int mismatches;
	int checked;
	int symbols;
	int long_symbols;

	function new();
		format_word = '0;
		mismatches = 0;
		checked = 0;
		symbols = 0;
		long_symbols = 0;
		clear_symbol();
	endfunction

	function void clear_symbol();
		bit_buf = '0;
		buf_bits = 0;
		payload_bits = 0;
		data_sent = 0;
		too_long = 1'b0;
		foreach (remainder[i]) remainder[i] = '0;
	endfunction

	function ecc_level_e level();
		logic [14:0] x;
		x = format_word ^ FMT_MASK;
		return ecc_level_e'(x[14:13]);
	endfunction

	function int unsigned ecc_len(ecc_level_e lvl);
		case (lvl)
			LVL_M: return 10;
			LVL_L: return 7;
			LVL_H: return 17;
			default: return 13;
		endcase
	endfunction

	// Payload capacity in bits at the current level.
	function int unsigned capacity();
		return SYMBOL_BITS - 8 * ecc_len(level());
	endfunction

	function logic [7:0] gen_coef(ecc_level_e lvl, int j);
		logic [135:0] row;
		case (lvl)
			LVL_M: row = {8'hd8, 8'hc2, 8'h9f, 8'h6f, 8'hc7, 8'h5e, 8'h5f, 8'h71, 8'h9d,
				8'hc1, 56'h0};
			LVL_L: row = {8'h7f, 8'h7a, 8'h9a, 8'ha4, 8'h0b, 8'h44, 8'h75, 80'h0};
			LVL_H: row = {8'h77, 8'h42, 8'h53, 8'h78, 8'h77, 8'h16, 8'hc5, 8'h53, 8'hf9,
				8'h29, 8'h8f, 8'h86, 8'h55, 8'h35, 8'h7d, 8'h63, 8'h4f};
			default: row = {8'h89, 8'h49, 8'he3, 8'h11, 8'hb1, 8'h11, 8'h34, 8'h0d, 8'h2e,
				8'h2b, 8'h53, 8'h84, 8'h78, 32'h0};
		endcase
		return row[8 * (16 - j) +: 8];
	endfunction

	function logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] x;
		acc = '0;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc ^= x;
			x = x[7] ? ((x << 1) ^ FIELD_POLY) : (x << 1);
		end
		return acc;
	endfunction

	// Emit one data codeword and clock it through the remainder row.
	function void push_data(logic [7:0] cw);
		ecc_level_e lvl;
		logic [7:0] factor;
		qr_word_t w;
		lvl = level();
		factor = cw ^ remainder[0];
		w = '{cw, 1'b0, STATUS_OK, 1'b0};
		codewords_due.push_back(w);
		for (int i = 0; i < 16; i++) remainder[i] = remainder[i + 1];
		remainder[16] = '0;
		for (int j = 0; j < ecc_len(lvl); j++) remainder[j] ^= gf_times(gen_coef(lvl, j), factor);
		data_sent++;
	endfunction

	function void push_bit(logic b);
		bit_buf = {bit_buf[6:0], b};
		buf_bits++;
		if (buf_bits == 8) begin
			push_data(bit_buf);
			bit_buf = '0;
			buf_bits = 0;
		end
	endfunction

	function void take_chunk(logic [7:0] bits, logic [3:0] cnt, logic last);
		ecc_level_e lvl;
		int unsigned n;
		int unsigned cap;
		int unsigned room;
		int unsigned term;
		int unsigned pads;
		qr_word_t w;
		lvl = level();
		cap = SYMBOL_BITS - 8 * ecc_len(lvl);
		n = (cnt > 8) ? 8 : cnt;
		if (!too_long) begin
			if (payload_bits + n > cap) begin
				too_long = 1'b1;
			end else begin
				for (int i = n; i > 0; i--) push_bit(bits[i - 1]);
				payload_bits += n;
			end
		end
		if (!last) return;
		symbols++;
		if (too_long) begin
			long_symbols++;
			w = '{8'h00, 1'b0, STATUS_TOO_LONG, 1'b1};
			codewords_due.push_back(w);
			clear_symbol();
			return;
		end
		// terminator, byte fill, then alternating pads up to capacity
		room = cap - payload_bits;
		term = (room > 4) ? 4 : room;
		repeat (term) push_bit(1'b0);
		while (buf_bits != 0) push_bit(1'b0);
		pads = 0;
		while (data_sent < cap / 8) begin
			push_data(pads[0] ? PAD_B : PAD_A);
			pads++;
		end
		for (int i = 0; i < ecc_len(lvl); i++) begin
			w = '{remainder[i], 1'b1, STATUS_OK, (i == ecc_len(lvl) - 1)};
			codewords_due.push_back(w);
		end
		clear_symbol();
	endfunction

	function void check_codeword(logic [7:0] cw, logic [1:0] user, logic last);
		qr_word_t w;
		checked++;
		if (codewords_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: unexpected word %02h ecc %0b status %0b last %0b",
					cw, user[0], user[1], last);
			return;
		end
		w = codewords_due.pop_front();
		if (w.codeword !== cw || w.is_ecc !== user[0] || w.status !== user[1] ||
				w.last !== last) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: word %0d (cw/ecc/status/last) expected %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
					checked, w.codeword, w.is_ecc, w.status, w.last,
					cw, user[0], user[1], last);
		end
	endfunction
endclass

module tb_qr_v1_codeword_ecc_encoder;
	localparam int WORD_TARGET = 450;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER = 230;
	localparam logic [1:0] FMT_MASK_TOP = 2'b10;   // bits 14..13 of the format mask
	localparam logic [14:0] FMT_ALL_ZERO = 15'h0000;  // decodes to level High
	localparam logic [14:0] FMT_ALL_ONE = 15'h7FFF;   // decodes to level Low

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [14:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;

	codeword_scoreboard sb = new();
	int words_in = 0;
	int cycles = 0;
	bit steady = 1'b0;
	bit held = 1'b0;

	qr_v1_codeword_ecc_encoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [14:0] format_for(input ecc_level_e lvl);
		logic [14:0] w;
		w = 15'($urandom);
		w[14:13] = lvl ^ FMT_MASK_TOP;
		return w;
	endfunction

	function automatic logic [14:0] pick_format();
		int sel;
		sel = $urandom_range(0, 7);
		if (sel == 0) return FMT_ALL_ZERO;
		if (sel == 1) return FMT_ALL_ONE;
		return format_for(ecc_level_e'($urandom_range(0, 3)));
	endfunction

	// Drain the output side and let the block settle before touching the register.
	task automatic write_format(input logic [14:0] value);
		s_tvalid <= 1'b0;
		while (sb.codewords_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.format_word = value;
	endtask

	task automatic send_word(input logic [7:0] bits, input logic [3:0] cnt, input logic last);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0000, cnt, bits};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		sb.take_chunk(bits, cnt, last);
		words_in++;
	endtask

	task automatic send_symbol(input int target);
		int remaining;
		int n;
		int sel;
		bit tail_empty;
		logic [3:0] cnt;
		tail_empty = ($urandom_range(0, 3) == 0) || (target == 0);
		remaining = target;
		while (remaining > 0) begin
			sel = $urandom_range(0, 15);
			if (sel == 0) begin
				cnt = 4'd0;
				n = 0;
			end else if (sel == 1 && remaining >= 8) begin
				cnt = 4'($urandom_range(9, 15));
				n = 8;
			end else begin
				n = $urandom_range(1, (remaining < 8) ? remaining : 8);
				cnt = 4'(n);
			end
			remaining -= n;
			send_word(8'($urandom), cnt, remaining == 0 && !tail_empty);
			// occasionally switch level in the middle of a symbol
			if (remaining > 0 && $urandom_range(0, 59) == 0) write_format(pick_format());
		end
		if (tail_empty) send_word(8'($urandom), 4'd0, 1'b1);
	endtask

	// Output side: random stalls, one long hold-off once the run is well underway.
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && words_in >= HOLD_AFTER) begin
				held = 1'b1;
				stall = HOLD_CYCLES;
			end else begin
				stall = steady ? 0 : $urandom_range(0, 4);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_codeword(m_tdata, m_tuser, m_tlast);
		end
	end

	initial begin
		int cap;
		int mode;
		int target;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		write_format(FMT_ALL_ZERO);

		// chunk-size corners: full byte, zero count, single bit, counts above eight
		send_word(8'hFF, 4'd8, 1'b0);
		send_word(8'hA5, 4'd0, 1'b0);
		send_word(8'h01, 4'd1, 1'b0);
		send_word(8'h5A, 4'd15, 1'b0);
		send_word(8'hC3, 4'd9, 1'b0);
		send_word(8'hF0, 4'd4, 1'b0);
		send_word(8'h03, 4'd3, 1'b1);

		// empty payload: terminator byte, then all pad
		write_format(FMT_ALL_ONE);
		send_word(8'h00, 4'd0, 1'b1);

		// start at level Low, finish at level High exactly at capacity
		repeat (5) send_word(8'($urandom), 4'd8, 1'b0);
		write_format(FMT_ALL_ZERO);
		repeat (4) send_word(8'($urandom), 4'd8, 1'b0);
		send_word(8'($urandom), 4'd0, 1'b1);

		// overrun level High by one bit
		repeat (9) send_word(8'($urandom), 4'd8, 1'b0);
		send_word(8'($urandom), 4'd1, 1'b0);
		send_word(8'($urandom), 4'd3, 1'b1);

		while (words_in < WORD_TARGET) begin
			if ($urandom_range(0, 1) == 0) write_format(pick_format());
			steady = ($urandom_range(0, 4) == 0);
			cap = sb.capacity();
			mode = $urandom_range(0, 9);
			if (mode == 0) target = cap + $urandom_range(1, 24);
			else if (mode == 1) target = cap;
			else target = $urandom_range(0, cap);
			send_symbol(target);
		end
		steady = 1'b0;

		s_tvalid <= 1'b0;
		while (sb.codewords_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d symbols (%0d too long) from %0d input words.",
			sb.symbols, sb.long_symbols, words_in);
		$display("Checked %0d codewords, %0d mismatches.", sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.codewords_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

### sim.f
hw/rtl/qre_pkg.sv
hw/rtl/qre_cell.sv
hw/rtl/qre_rs_chain.sv
hw/rtl/qr_v1_codeword_ecc_encoder.sv
bench/tb_qr_v1_codeword_ecc_encoder.sv
